/* rtl/core/trk_tmr_pkg.sv */
// ----------------------------------------------------------------------------
// trk_tmr_pkg
// Types, codes and constants shared by the trickle interval timer.
// ----------------------------------------------------------------------------
`default_nettype none

package trk_tmr_pkg;

    localparam int unsigned EXP_W     = 5;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned TICK_W    = 22;
    localparam int unsigned HALF_W    = TICK_W - 1;
    localparam int unsigned RAND_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    localparam int unsigned MAX_EXP_DEF          = 24;
    localparam int unsigned TICKS_PER_SECOND_DEF = 128;
    localparam int unsigned MS_PER_SEC           = 1000;
    localparam int unsigned RAND_TOP             = (1 << RAND_W) - 1;

    localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [EXP_W-1:0] MIN_EXP_RST    = 5'd12;
    localparam logic [EXP_W-1:0] DOUBLINGS_RST  = 5'd8;
    localparam logic [CNT_W-1:0] REDUNDANCY_RST = 8'd10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_HEARD = 2'd1,
        OP_RESET = 2'd2,
        OP_START = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_TRANSMIT = 3'd1,
        EV_SUPPRESS = 3'd2,
        EV_POSTPONE = 3'd3,
        EV_NEW_INTV = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_EXP    = 2'd0,
        CFG_DOUBLINGS  = 2'd1,
        CFG_REDUNDANCY = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_op               op;
        logic [RAND_W-1:0] rand_word;
        logic              addr_ready;
    } t_in_item;

    typedef struct packed {
        t_event            event_res;
        logic [EXP_W-1:0]  interval_exp;
        logic [CNT_W-1:0]  consistent_count;
    } t_out_item;

    // Interval length in ticks for every exponent code.
    typedef logic [(1 << EXP_W)-1:0][TICK_W-1:0] t_tick_tbl;

    // Elaboration-time only: 2^e ms scaled to ticks, saturated.
    function automatic t_tick_tbl ticks_table(input int unsigned tps);
        t_tick_tbl   tbl;
        logic [63:0] t;
        for (int e = 0; e < (1 << EXP_W); e++) begin
            t = ((64'd1 << e) * 64'(tps)) / MS_PER_SEC;
            if (t > 64'(TICK_MAX)) begin
                t = 64'(TICK_MAX);
            end
            tbl[e] = t[TICK_W-1:0];
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/trickle_interval_timer_unit.sv */
// ----------------------------------------------------------------------------
// trickle_interval_timer_unit
// Trickle transmission timer: interval draw, fire/suppress and doubling.
// ----------------------------------------------------------------------------
// Takes one op (tick, consistent message heard, reset to minimum, start) per
// clock and returns exactly one result per op, registered, in the cycle after
// the transfer. All state is updated by a single combinational step: a
// table lookup of the interval length, one 21x16 multiply and a constant
// division by 65535 done with adds, so a new op is taken every cycle as long
// as the result register is empty or being drained in the same cycle. The
// configuration port is always ready; write it only while no op is in flight.
`default_nettype none

module trickle_interval_timer_unit #(
    parameter int unsigned TICKS_PER_SECOND = trk_tmr_pkg::TICKS_PER_SECOND_DEF,
    parameter int unsigned MAX_EXP          = trk_tmr_pkg::MAX_EXP_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // op channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  trk_tmr_pkg::t_in_item                i_in,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output trk_tmr_pkg::t_out_item               o_out,
    // configuration writes
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [trk_tmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [trk_tmr_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int unsigned EXP_W  = trk_tmr_pkg::EXP_W;
    localparam int unsigned CNT_W  = trk_tmr_pkg::CNT_W;
    localparam int unsigned TICK_W = trk_tmr_pkg::TICK_W;
    localparam int unsigned HALF_W = trk_tmr_pkg::HALF_W;
    localparam int unsigned RAND_W = trk_tmr_pkg::RAND_W;
    localparam int unsigned PROD_W = HALF_W + RAND_W;

    localparam trk_tmr_pkg::t_tick_tbl TICK_TBL =
        trk_tmr_pkg::ticks_table(TICKS_PER_SECOND);
    localparam logic [EXP_W-1:0]  MAX_EXP_V  = EXP_W'(MAX_EXP);
    localparam logic [TICK_W-1:0] POSTPONE_T = TICK_W'(TICKS_PER_SECOND);

    // configuration
    logic [EXP_W-1:0] r_min_exp;
    logic [EXP_W-1:0] r_doublings;
    logic [CNT_W-1:0] r_redundancy;

    // timer state
    logic [EXP_W-1:0]  r_cur_exp,      n_cur_exp;
    logic [CNT_W-1:0]  r_heard,        n_heard;
    logic              r_fire_pending, n_fire_pending;
    logic [TICK_W-1:0] r_ticks_left,   n_ticks_left;
    logic [TICK_W-1:0] r_tail_ticks,   n_tail_ticks;
    logic              r_running,      n_running;
    logic              r_addr_ok,      n_addr_ok;

    // result register
    logic                   r_out_valid;
    trk_tmr_pkg::t_out_item r_out;
    trk_tmr_pkg::t_event    n_event;

    logic             in_xfer;
    logic             do_begin;
    logic [EXP_W-1:0] eff_min;
    logic [EXP_W:0]   ceil_sum;
    logic [EXP_W-1:0] exp_ceil;

    // interval draw
    logic [TICK_W-1:0] intv_ticks;
    logic [HALF_W-1:0] half;
    logic [PROD_W-1:0] prod;
    logic [TICK_W-1:0] fold1;
    logic [RAND_W:0]   fold2;
    logic [TICK_W-1:0] quot;
    logic [TICK_W-1:0] fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        eff_min  = (r_min_exp > MAX_EXP_V) ? MAX_EXP_V : r_min_exp;
        ceil_sum = {1'b0, r_min_exp} + {1'b0, r_doublings};
        exp_ceil = (ceil_sum > {1'b0, MAX_EXP_V}) ? MAX_EXP_V : ceil_sum[EXP_W-1:0];
    end

    always_comb begin
        n_cur_exp      = r_cur_exp;
        n_heard        = r_heard;
        n_fire_pending = r_fire_pending;
        n_ticks_left   = r_ticks_left;
        n_tail_ticks   = r_tail_ticks;
        n_running      = r_running;
        n_addr_ok      = r_addr_ok;
        n_event        = trk_tmr_pkg::EV_NONE;
        do_begin       = 1'b0;

        case (i_in.op)
            trk_tmr_pkg::OP_TICK: begin
                if (r_running) begin
                    if (r_ticks_left > TICK_W'(1)) begin
                        n_ticks_left = r_ticks_left - TICK_W'(1);
                    end else if (!r_addr_ok && !i_in.addr_ready) begin
                        // hold expiry back one second until the address exists
                        n_ticks_left = POSTPONE_T;
                        n_event      = trk_tmr_pkg::EV_POSTPONE;
                    end else begin
                        n_addr_ok = 1'b1;
                        if (r_fire_pending) begin
                            n_event = (r_heard < r_redundancy) ?
                                      trk_tmr_pkg::EV_TRANSMIT : trk_tmr_pkg::EV_SUPPRESS;
                            n_fire_pending = 1'b0;
                            n_ticks_left   = r_tail_ticks;
                        end else begin
                            if (r_cur_exp < exp_ceil) begin
                                n_cur_exp = r_cur_exp + EXP_W'(1);
                            end
                            do_begin = 1'b1;
                        end
                    end
                end
            end
            trk_tmr_pkg::OP_HEARD: begin
                if (r_heard != trk_tmr_pkg::COUNT_MAX) begin
                    n_heard = r_heard + CNT_W'(1);
                end
            end
            trk_tmr_pkg::OP_RESET: begin
                if (r_cur_exp > eff_min) begin
                    n_cur_exp = eff_min;
                    do_begin  = 1'b1;
                end
            end
            trk_tmr_pkg::OP_START: begin
                n_cur_exp = eff_min;
                do_begin  = 1'b1;
            end
            default: begin
                n_event = trk_tmr_pkg::EV_NONE;
            end
        endcase

        // fire = half + floor(half * rand / 65535), division folded into adds
        intv_ticks = TICK_TBL[n_cur_exp];
        half       = intv_ticks[TICK_W-1:1];
        prod       = PROD_W'(half) * PROD_W'(i_in.rand_word);
        fold1      = TICK_W'(prod[PROD_W-1:RAND_W]) + TICK_W'(prod[RAND_W-1:0]);
        fold2      = (RAND_W+1)'(fold1[TICK_W-1:RAND_W]) + (RAND_W+1)'(fold1[RAND_W-1:0]);
        quot       = TICK_W'(prod[PROD_W-1:RAND_W]) + TICK_W'(fold1[TICK_W-1:RAND_W])
                   + TICK_W'(fold2 >= (RAND_W+1)'(trk_tmr_pkg::RAND_TOP));
        fire       = TICK_W'(half) + quot;

        if (do_begin) begin
            n_ticks_left   = fire;
            n_tail_ticks   = intv_ticks - fire;
            n_fire_pending = 1'b1;
            n_heard        = '0;
            n_running      = 1'b1;
            n_event        = trk_tmr_pkg::EV_NEW_INTV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_exp    <= trk_tmr_pkg::MIN_EXP_RST;
            r_doublings  <= trk_tmr_pkg::DOUBLINGS_RST;
            r_redundancy <= trk_tmr_pkg::REDUNDANCY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                trk_tmr_pkg::CFG_MIN_EXP:    r_min_exp    <= i_cfg_data[EXP_W-1:0];
                trk_tmr_pkg::CFG_DOUBLINGS:  r_doublings  <= i_cfg_data[EXP_W-1:0];
                trk_tmr_pkg::CFG_REDUNDANCY: r_redundancy <= i_cfg_data[CNT_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_exp      <= '0;
            r_heard        <= '0;
            r_fire_pending <= 1'b0;
            r_ticks_left   <= '0;
            r_tail_ticks   <= '0;
            r_running      <= 1'b0;
            r_addr_ok      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_cur_exp      <= n_cur_exp;
                r_heard        <= n_heard;
                r_fire_pending <= n_fire_pending;
                r_ticks_left   <= n_ticks_left;
                r_tail_ticks   <= n_tail_ticks;
                r_running      <= n_running;
                r_addr_ok      <= n_addr_ok;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.event_res        <= n_event;
            r_out.interval_exp     <= n_cur_exp;
            r_out.consistent_count <= n_heard;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_start_begins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.op == trk_tmr_pkg::OP_START
        |=> r_running && r_fire_pending && r_heard == '0
            && r_out.event_res == trk_tmr_pkg::EV_NEW_INTV)
        else $error("start op did not open a new interval");

    a_postpone_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && n_event == trk_tmr_pkg::EV_POSTPONE
        |=> r_ticks_left == POSTPONE_T && r_out.event_res == trk_tmr_pkg::EV_POSTPONE)
        else $error("postponed expiry did not reload one second");

    a_pending_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_pending |-> r_running)
        else $error("fire point pending while timer stopped");

    a_exp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid && r_cur_exp <= MAX_EXP_V)
        else $error("result missing or exponent above ceiling");

endmodule

`default_nettype wire

/* sim/trickle_interval_timer_unit_tb.sv */
// ----------------------------------------------------------------------------
// trickle_interval_timer_unit_tb
// Self-checking bench for the trickle interval timer.
// ----------------------------------------------------------------------------
// A short table of hand-picked ops covers the stopped timer, every op, the
// address postponement, fire/suppress, doubling up to the ceiling and the
// masking of register writes. Random phases follow, each under its own
// register setting, including a long run of heard messages that saturates the
// counter. Table rows with an expected result are checked against it, all
// other results against an in-bench timer model. Both sides idle at random,
// and the result side holds off for long stretches to back the block up.
`default_nettype none

module trickle_interval_timer_unit_tb;
    import trk_tmr_pkg::*;

    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 64;
    localparam int unsigned QUIET_LIMIT   = 1000;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned BURST_PHASE   = 6;
    localparam int unsigned HEARD_BURST   = 260;

    // Index past the last register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [CFG_DAT_W-1:0] cfg_data;
        t_in_item             op_item;
        logic                 typed;
        t_out_item            want;
    } t_dir_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Timer model: register copies and running state.
    logic [EXP_W-1:0]  cfg_min_exp    = MIN_EXP_RST;
    logic [EXP_W-1:0]  cfg_doublings  = DOUBLINGS_RST;
    logic [CNT_W-1:0]  cfg_redundancy = REDUNDANCY_RST;
    logic [EXP_W-1:0]  cur_exp        = '0;
    logic [CNT_W-1:0]  heard          = '0;
    logic              fire_pending   = 1'b0;
    logic [TICK_W-1:0] ticks_left     = '0;
    logic [TICK_W-1:0] tail_ticks     = '0;
    logic              running        = 1'b0;
    logic              addr_ok        = 1'b0;

    t_out_item   step_outcomes[$];
    t_dir_row    directed_rows[$];
    int unsigned err_count  = 0;
    int unsigned ops_sent   = 0;
    int unsigned res_seen   = 0;
    int unsigned reg_writes = 0;
    int unsigned event_tally[5] = '{0, 0, 0, 0, 0};
    logic        feed_calm = 1'b0;
    logic        sink_calm = 1'b0;

    int unsigned phase_min  [NUM_PHASES] = '{0, 3, 0, 5, 2, 31, 4, 1};
    int unsigned phase_dbl  [NUM_PHASES] = '{0, 3, 6, 2, 31, 31, 1, 4};
    int unsigned phase_red  [NUM_PHASES] = '{0, 1, 2, 255, 3, 255, 255, 5};
    int unsigned phase_items[NUM_PHASES] = '{40, 40, 40, 35, 40, 20, 280, 40};

    trickle_interval_timer_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [EXP_W-1:0] floor_exp();
        if (cfg_min_exp > MAX_EXP_DEF) begin
            return EXP_W'(MAX_EXP_DEF);
        end
        return cfg_min_exp;
    endfunction

    function automatic int unsigned exp_ceiling();
        int unsigned lim;
        lim = int'(cfg_min_exp) + int'(cfg_doublings);
        return (lim > MAX_EXP_DEF) ? MAX_EXP_DEF : lim;
    endfunction

    // Draw the fire point between half and all of the interval.
    function automatic void open_interval(input logic [RAND_W-1:0] rnd);
        logic [63:0] span;
        logic [63:0] half;
        logic [63:0] fire;
        logic [63:0] rest;
        span = ((64'd1 << cur_exp) * 64'(TICKS_PER_SECOND_DEF)) / 64'(MS_PER_SEC);
        if (span > 64'(TICK_MAX)) begin
            span = 64'(TICK_MAX);
        end
        half = span >> 1;
        fire = half + (half * 64'(rnd)) / 64'(RAND_TOP);
        rest = span - fire;
        tail_ticks   = rest[TICK_W-1:0];
        ticks_left   = fire[TICK_W-1:0];
        fire_pending = 1'b1;
        heard        = '0;
        running      = 1'b1;
    endfunction

    function automatic t_out_item trickle_step(input t_in_item item);
        t_out_item res;
        t_event    ev;
        ev = EV_NONE;
        case (item.op)
            OP_TICK: begin
                if (running) begin
                    if (ticks_left > 1) begin
                        ticks_left--;
                    end else if (!addr_ok && !item.addr_ready) begin
                        ticks_left = TICK_W'(TICKS_PER_SECOND_DEF);
                        ev = EV_POSTPONE;
                    end else begin
                        addr_ok = 1'b1;
                        if (fire_pending) begin
                            ev = (heard < cfg_redundancy) ? EV_TRANSMIT : EV_SUPPRESS;
                            fire_pending = 1'b0;
                            ticks_left = tail_ticks;
                        end else begin
                            if (int'(cur_exp) < exp_ceiling()) begin
                                cur_exp++;
                            end
                            open_interval(item.rand_word);
                            ev = EV_NEW_INTV;
                        end
                    end
                end
            end
            OP_HEARD: begin
                if (heard != COUNT_MAX) begin
                    heard++;
                end
            end
            OP_RESET: begin
                if (cur_exp > floor_exp()) begin
                    cur_exp = floor_exp();
                    open_interval(item.rand_word);
                    ev = EV_NEW_INTV;
                end
            end
            default: begin
                cur_exp = floor_exp();
                open_interval(item.rand_word);
                ev = EV_NEW_INTV;
            end
        endcase
        res.event_res        = ev;
        res.interval_exp     = cur_exp;
        res.consistent_count = heard;
        return res;
    endfunction

    function automatic t_dir_row op_row(input t_op op, input logic [RAND_W-1:0] rnd,
                                        input logic rdy, input t_event ev,
                                        input logic [EXP_W-1:0] e,
                                        input logic [CNT_W-1:0] c);
        t_dir_row row;
        row = '0;
        row.op_item.op         = op;
        row.op_item.rand_word  = rnd;
        row.op_item.addr_ready = rdy;
        row.typed                 = 1'b1;
        row.want.event_res        = ev;
        row.want.interval_exp     = e;
        row.want.consistent_count = c;
        return row;
    endfunction

    function automatic t_dir_row free_row(input t_op op, input logic [RAND_W-1:0] rnd,
                                          input logic rdy);
        t_dir_row row;
        row = '0;
        row.op_item.op         = op;
        row.op_item.rand_word  = rnd;
        row.op_item.addr_ready = rdy;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_DAT_W-1:0] data);
        t_dir_row row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_index = index;
        row.cfg_data  = data;
        return row;
    endfunction

    task automatic flag_error(input string what, input int unsigned got,
                              input int unsigned want);
        $display("mismatch on result %0d: %s got %0d, want %0d", res_seen, what, got, want);
        err_count++;
    endtask

    task automatic take_result(input t_out_item got);
        t_out_item want;
        res_seen++;
        if (step_outcomes.size() == 0) begin
            flag_error("result with none outstanding, event", got.event_res, EV_NONE);
        end else begin
            want = step_outcomes.pop_front();
            event_tally[want.event_res]++;
            if (got.event_res !== want.event_res) begin
                flag_error("event", got.event_res, want.event_res);
            end
            if (got.interval_exp !== want.interval_exp) begin
                flag_error("interval exponent", got.interval_exp, want.interval_exp);
            end
            if (got.consistent_count !== want.consistent_count) begin
                flag_error("consistent count", got.consistent_count,
                           want.consistent_count);
            end
        end
    endtask

    // Offer one op after a random gap (none while feed_calm is set); the outcome is queued at the transfer.
    task automatic send_op(input t_in_item item, input logic typed,
                           input t_out_item typed_want);
        int unsigned gap;
        t_out_item   predicted;
        gap = feed_calm ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        predicted = trickle_step(item);
        step_outcomes.push_back(typed ? typed_want : predicted);
        ops_sent++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (step_outcomes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        if (index == CFG_MIN_EXP) begin
            cfg_min_exp = data[EXP_W-1:0];
        end else if (index == CFG_DOUBLINGS) begin
            cfg_doublings = data[EXP_W-1:0];
        end else if (index == CFG_REDUNDANCY) begin
            cfg_redundancy = data;
        end
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (res_seen == 80 || res_seen == 320) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = sink_calm ? 0 : $urandom_range(0, 5);
            end
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            take_result(out_item);
            if (res_seen % 32 == 0) begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_in_item    item;
        int unsigned pick;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        directed_rows = '{
            // stopped timer: ticks do nothing, reset op has nothing to lower
            op_row(OP_TICK,  16'h0000, 1'b0, EV_NONE,     5'd0,  8'd0),
            op_row(OP_HEARD, 16'h0000, 1'b0, EV_NONE,     5'd0,  8'd1),
            op_row(OP_RESET, 16'h0000, 1'b0, EV_NONE,     5'd0,  8'd1),
            op_row(OP_START, 16'h0000, 1'b0, EV_NEW_INTV, 5'd12, 8'd0),
            op_row(OP_HEARD, 16'hFFFF, 1'b1, EV_NONE,     5'd12, 8'd1),
            op_row(OP_START, 16'hFFFF, 1'b0, EV_NEW_INTV, 5'd12, 8'd0),
            free_row(OP_TICK, 16'h0000, 1'b1),
            // upper data bits are masked off: minimum becomes zero
            cfg_row(CFG_MIN_EXP,    8'hE0),
            cfg_row(CFG_DOUBLINGS,  8'h02),
            cfg_row(CFG_REDUNDANCY, 8'h00),
            op_row(OP_RESET, 16'h1234, 1'b0, EV_NEW_INTV, 5'd0, 8'd0),
            // expiry before the address exists is pushed out by a second
            op_row(OP_TICK,  16'h0000, 1'b0, EV_POSTPONE, 5'd0, 8'd0),
            op_row(OP_START, 16'hA5A5, 1'b0, EV_NEW_INTV, 5'd0, 8'd0),
            op_row(OP_TICK,  16'h0000, 1'b1, EV_SUPPRESS, 5'd0, 8'd0),
            // zero-length intervals: alternate fire and doubling up to the ceiling
            op_row(OP_TICK,  16'h5A5A, 1'b0, EV_NEW_INTV, 5'd1, 8'd0),
            op_row(OP_TICK,  16'h0000, 1'b0, EV_SUPPRESS, 5'd1, 8'd0),
            op_row(OP_TICK,  16'hFFFF, 1'b1, EV_NEW_INTV, 5'd2, 8'd0),
            op_row(OP_TICK,  16'h0000, 1'b0, EV_SUPPRESS, 5'd2, 8'd0),
            op_row(OP_TICK,  16'h8000, 1'b0, EV_NEW_INTV, 5'd2, 8'd0),
            cfg_row(CFG_REDUNDANCY, 8'hFF),
            op_row(OP_HEARD, 16'h0000, 1'b0, EV_NONE,     5'd2, 8'd1),
            op_row(OP_TICK,  16'h0000, 1'b0, EV_TRANSMIT, 5'd2, 8'd1),
            // minimum above the exponent limit acts as the limit
            cfg_row(CFG_MIN_EXP,   8'hFF),
            cfg_row(CFG_DOUBLINGS, 8'hFF),
            cfg_row(CFG_IDX_SPARE, 8'h55),
            op_row(OP_START, 16'hFFFF, 1'b1, EV_NEW_INTV, 5'd24, 8'd0),
            op_row(OP_RESET, 16'h0000, 1'b0, EV_NONE,     5'd24, 8'd0),
            free_row(OP_TICK, 16'h0000, 1'b0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                settle();
                write_reg(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
            end else begin
                send_op(directed_rows[i].op_item, directed_rows[i].typed,
                        directed_rows[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_MIN_EXP, {3'($urandom_range(0, 7)), 5'(phase_min[p])});
            write_reg(CFG_DOUBLINGS, {3'($urandom_range(0, 7)), 5'(phase_dbl[p])});
            write_reg(CFG_REDUNDANCY, 8'(phase_red[p]));
            feed_calm = (p % 3 == 1);
            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(0, 99);
                if (n == 0) begin
                    item.op = OP_START;
                end else if (p == BURST_PHASE && n <= HEARD_BURST) begin
                    // drive the heard counter into saturation
                    item.op = OP_HEARD;
                end else if (pick < 70) begin
                    item.op = OP_TICK;
                end else if (pick < 84) begin
                    item.op = OP_HEARD;
                end else if (pick < 92) begin
                    item.op = OP_RESET;
                end else begin
                    item.op = OP_START;
                end
                case ($urandom_range(0, 7))
                    0:       item.rand_word = '0;
                    1:       item.rand_word = '1;
                    default: item.rand_word = RAND_W'($urandom_range(0, RAND_TOP));
                endcase
                item.addr_ready = 1'($urandom_range(0, 1));
                send_op(item, 1'b0, '0);
            end
        end

        settle();
        $display("ran %0d timer ops under %0d register writes, %0d results checked",
                 ops_sent, reg_writes, res_seen);
        $display("events: %0d transmit, %0d suppressed, %0d postponed, %0d new interval",
                 event_tally[EV_TRANSMIT], event_tally[EV_SUPPRESS],
                 event_tally[EV_POSTPONE], event_tally[EV_NEW_INTV]);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* trickle_interval_timer_unit.f */
rtl/core/trk_tmr_pkg.sv
rtl/core/trickle_interval_timer_unit.sv
sim/trickle_interval_timer_unit_tb.sv
